// ----- hw/rtl/qvr_pkg.sv -----
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ANGLE_BITS_DEF = 16;
    // CORDIC datapath width (x, y, z)
    localparam int CW = 33;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sh026DD3B6A;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 upper;
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic signed [31:0]   pz;
        logic signed [15:0]   ax;
        logic signed [15:0]   ay;
        logic signed [15:0]   az;
    } t_cordic;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [CW-1:0] f_atan(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 33'sh020000000;
            1:  v = 33'sh012E4051E;
            2:  v = 33'sh009FB385B;
            3:  v = 33'sh0051111D4;
            4:  v = 33'sh0028B0D43;
            5:  v = 33'sh00145D7E1;
            6:  v = 33'sh000A2F61E;
            7:  v = 33'sh000517C55;
            8:  v = 33'sh00028BE53;
            9:  v = 33'sh000145F2F;
            10: v = 33'sh0000A2F98;
            11: v = 33'sh0000517CC;
            12: v = 33'sh000028BE6;
            13: v = 33'sh0000145F3;
            14: v = 33'sh00000A2FA;
            15: v = 33'sh00000517D;
            16: v = 33'sh0000028BE;
            17: v = 33'sh00000145F;
            18: v = 33'sh000000A30;
            19: v = 33'sh000000518;
            20: v = 33'sh00000028C;
            21: v = 33'sh000000146;
            22: v = 33'sh0000000A3;
            23: v = 33'sh000000051;
            24: v = 33'sh000000029;
            25: v = 33'sh000000014;
            26: v = 33'sh00000000A;
            27: v = 33'sh000000005;
            28: v = 33'sh000000003;
            29: v = 33'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/qvr_cell.sv -----
`timescale 1ns / 1ps

module qvr_cell #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  qvr_pkg::t_cordic   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output qvr_pkg::t_cordic   o_data
);

    logic                      r_valid;
    qvr_pkg::t_cordic          r_data;
    qvr_pkg::t_cordic          n_data;
    logic signed [qvr_pkg::CW-1:0] dx;
    logic signed [qvr_pkg::CW-1:0] dy;

    assign o_ready = !r_valid || i_ready;

    // one micro-rotation, direction from the residual angle sign
    always_comb begin
        dx     = i_data.y >>> STEP;
        dy     = i_data.x >>> STEP;
        n_data = i_data;
        if (!i_data.z[qvr_pkg::CW-1]) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - qvr_pkg::f_atan(STEP);
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + qvr_pkg::f_atan(STEP);
        end
    end

    // load when empty or when the next cell can take the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hw/rtl/qvr_post.sv -----
`timescale 1ns / 1ps

module qvr_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  qvr_pkg::t_cordic   i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_rx,
    output logic signed [31:0] o_ry,
    output logic signed [31:0] o_rz,
    output logic               o_sat
);

    localparam int NS = 6;

    logic [NS-1:0] r_v;
    logic [NS-1:0] rdy;

    // stage 1: trig fold, w, axis * sin
    logic signed [22:0] r1_w;
    logic signed [48:0] r1_pa [3];
    logic signed [31:0] r1_p  [3];
    // stage 2: u, w*w
    logic signed [23:0] r2_u  [3];
    logic signed [22:0] r2_w;
    logic signed [45:0] r2_ww;
    logic signed [31:0] r2_p  [3];
    // stage 3: products
    logic signed [47:0] r3_uu [3];
    logic signed [55:0] r3_up [3][3];
    logic signed [45:0] r3_ww;
    logic signed [23:0] r3_u  [3];
    logic signed [22:0] r3_w;
    logic signed [31:0] r3_p  [3];
    // stage 4: k, d, cross
    logic signed [31:0] r4_k;
    logic signed [39:0] r4_d;
    logic signed [39:0] r4_cr [3];
    logic signed [23:0] r4_u  [3];
    logic signed [22:0] r4_w;
    logic signed [31:0] r4_p  [3];
    // stage 5: terms
    logic signed [63:0] r5_a  [3];
    logic signed [63:0] r5_b  [3];
    logic signed [63:0] r5_c  [3];
    // stage 6: result
    logic signed [31:0] r6_r  [3];
    logic               r6_sat;

    logic signed [32:0] c1;
    logic signed [32:0] s1;
    logic signed [32:0] w1;
    logic signed [48:0] u2  [3];
    logic signed [51:0] k4;
    logic signed [57:0] d4;
    logic signed [57:0] cr4 [3];
    logic signed [65:0] r6  [3];
    logic [2:0]         sat6;

    // per-stage handshake: a stage loads when empty or draining
    always_comb begin
        rdy[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // stage 1
    always_comb begin
        c1 = i_data.upper ? -i_data.y : i_data.x;
        s1 = i_data.upper ? i_data.x : i_data.y;
        w1 = (c1 + 33'sd512) >>> 10;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_w     <= w1[22:0];
            r1_pa[0] <= 49'(i_data.ax) * 49'(s1);
            r1_pa[1] <= 49'(i_data.ay) * 49'(s1);
            r1_pa[2] <= 49'(i_data.az) * 49'(s1);
            r1_p[0]  <= i_data.px;
            r1_p[1]  <= i_data.py;
            r1_p[2]  <= i_data.pz;
        end
    end

    // stage 2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u2[i] = (r1_pa[i] + (49'sd1 <<< 23)) >>> 24;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                r2_u[i] <= u2[i][23:0];
                r2_p[i] <= r1_p[i];
            end
            r2_w  <= r1_w;
            r2_ww <= 46'(r1_w) * 46'(r1_w);
        end
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_uu[i] <= 48'(r2_u[i]) * 48'(r2_u[i]);
                for (int j = 0; j < 3; j++) begin
                    r3_up[i][j] <= 56'(r2_u[i]) * 56'(r2_p[j]);
                end
                r3_u[i] <= r2_u[i];
                r3_p[i] <= r2_p[i];
            end
            r3_ww <= r2_ww;
            r3_w  <= r2_w;
        end
    end

    // stage 4: sums and rounding
    always_comb begin
        k4 = (52'(r3_ww) - 52'(r3_uu[0]) - 52'(r3_uu[1]) - 52'(r3_uu[2])
              + (52'sd1 <<< 19)) >>> 20;
        d4 = (58'(r3_up[0][0]) + 58'(r3_up[1][1]) + 58'(r3_up[2][2])
              + (58'sd1 <<< 19)) >>> 20;
        cr4[0] = (58'(r3_up[1][2]) - 58'(r3_up[2][1]) + (58'sd1 <<< 19)) >>> 20;
        cr4[1] = (58'(r3_up[2][0]) - 58'(r3_up[0][2]) + (58'sd1 <<< 19)) >>> 20;
        cr4[2] = (58'(r3_up[0][1]) - 58'(r3_up[1][0]) + (58'sd1 <<< 19)) >>> 20;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r4_k <= k4[31:0];
            r4_d <= d4[39:0];
            for (int i = 0; i < 3; i++) begin
                r4_cr[i] <= cr4[i][39:0];
                r4_u[i]  <= r3_u[i];
                r4_p[i]  <= r3_p[i];
            end
            r4_w <= r3_w;
        end
    end

    // stage 5: the three terms per component
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            for (int i = 0; i < 3; i++) begin
                r5_a[i] <= 64'(r4_k) * 64'(r4_p[i]);
                r5_b[i] <= (64'(r4_d) <<< 1) * 64'(r4_u[i]);
                r5_c[i] <= (64'(r4_w) <<< 1) * 64'(r4_cr[i]);
            end
        end
    end

    // stage 6: sum, round, clip
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r6[i] = (66'(r5_a[i]) + 66'(r5_b[i]) + 66'(r5_c[i])
                     + (66'sd1 <<< 19)) >>> 20;
            sat6[i] = (r6[i] > 66'sd2147483647) || (r6[i] < -66'sd2147483648);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            for (int i = 0; i < 3; i++) begin
                if (r6[i] > 66'sd2147483647) begin
                    r6_r[i] <= 32'sh7FFFFFFF;
                end else if (r6[i] < -66'sd2147483648) begin
                    r6_r[i] <= 32'sh80000000;
                end else begin
                    r6_r[i] <= r6[i][31:0];
                end
            end
            r6_sat <= |sat6;
        end
    end

    assign o_rx  = r6_r[0];
    assign o_ry  = r6_r[1];
    assign o_rz  = r6_r[2];
    assign o_sat = r6_sat;

endmodule

// ----- hw/rtl/quaternion_vector_rotate.sv -----
// Pipeline: 30 CORDIC cells, then 6 product and sum stages in qvr_post, each registered.
// Throughput: one item per cycle while i_out_ready holds; every cell and stage has its own valid and
// loads whenever it is empty or its successor takes its item.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps

module quaternion_vector_rotate #(
    parameter int ANGLE_BITS = qvr_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [31:0]    i_point_x,
    input  logic signed [31:0]    i_point_y,
    input  logic signed [31:0]    i_point_z,
    input  logic signed [15:0]    i_axis_x,
    input  logic signed [15:0]    i_axis_y,
    input  logic signed [15:0]    i_axis_z,
    input  logic [ANGLE_BITS-1:0] i_turn_angle,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_rotated_x,
    output logic signed [31:0]    o_rotated_y,
    output logic signed [31:0]    o_rotated_z,
    output logic                  o_saturated
);

    localparam int N = qvr_pkg::CORDIC_STEPS;

    logic             v   [N+1];
    logic             rd  [N+1];
    qvr_pkg::t_cordic d   [N+1];
    logic [30:0]      half;

    // half angle in 2^-32 turn units, folded into the first quarter
    always_comb begin
        half       = 31'(i_turn_angle) << (31 - ANGLE_BITS);
        d[0].x     = qvr_pkg::CORDIC_GAIN;
        d[0].y     = '0;
        d[0].z     = qvr_pkg::CW'({1'b0, half[29:0]});
        d[0].upper = half[30];
        d[0].px    = i_point_x;
        d[0].py    = i_point_y;
        d[0].pz    = i_point_z;
        d[0].ax    = i_axis_x;
        d[0].ay    = i_axis_y;
        d[0].az    = i_axis_z;
    end

    assign v[0]       = i_in_valid;
    assign o_in_ready = rd[0];

    // CORDIC chain
    for (genvar g = 0; g < N; g++) begin : g_cell
        qvr_cell #(
            .STEP(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g]),
            .o_ready (rd[g]),
            .i_data  (d[g]),
            .o_valid (v[g+1]),
            .i_ready (rd[g+1]),
            .o_data  (d[g+1])
        );
    end

    qvr_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[N]),
        .o_ready (rd[N]),
        .i_data  (d[N]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_rx    (o_rotated_x),
        .o_ry    (o_rotated_y),
        .o_rz    (o_rotated_z),
        .o_sat   (o_saturated)
    );

endmodule
